FILE: rtl/imuca_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables for the IMU complementary attitude block.
package imuca_pkg;

	// Stream payload widths
	localparam int S_DATA_W = 112;
	localparam int M_DATA_W = 120;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd1;
	localparam logic [15:0] GAIN_RESET   = 16'd5115;
	localparam logic [16:0] WEIGHT_RESET = 17'd62415;
	localparam logic [16:0] WEIGHT_ONE   = 17'd65536;

	// CORDIC datapath
	localparam int XW      = 34;   // x/y working width
	localparam int ZW      = 26;   // angle width, signed Q10.16 degrees
	localparam int TAB_LEN = 24;
	localparam logic signed [ZW-1:0] Z_QUARTER = 26'sd5898240;  // 90 degrees

	// Shared multiplier
	localparam int MA_W = 33;
	localparam int MB_W = 18;
	localparam int MP_W = MA_W + MB_W;

	// Temperature: floor(M / 34000) via reciprocal floor(2^32 / 34000)
	localparam logic [MB_W-1:0] TEMP_RECIP  = 18'd126322;
	localparam logic [MB_W-1:0] TEMP_DIV    = 18'd34000;
	localparam logic signed [31:0] TEMP_GAIN = 32'sd25600;
	localparam logic signed [31:0] TEMP_OFS  = 32'sd875030120;  // bias + rounding + 16384*34000
	localparam logic [17:0] TEMP_BIAS_Q  = 18'd16384;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_PITCH_GO,
		ST_PITCH_RUN,
		ST_ROLL_GO,
		ST_ROLL_RUN,
		ST_POST,
		ST_DONE
	} imuca_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_stat_t;

	// atan(2^-i) in Q16.16 degrees
	function automatic logic [21:0] atan_entry(input logic [4:0] idx);
		logic [21:0] v;
		case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58665;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	// Clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [MP_W-1:0] v);
		logic signed [31:0] r;
		if (v > 51'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -51'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/imuca_mul.sv
`timescale 1ns / 1ps
// Shared signed 33x18 multiplier with registered product.
module imuca_mul (
	input  logic                                clk,
	input  logic signed [imuca_pkg::MA_W-1:0]   a,
	input  logic signed [imuca_pkg::MB_W-1:0]   b,
	output logic signed [imuca_pkg::MP_W-1:0]   p_q
);

	logic signed [imuca_pkg::MP_W-1:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		p_q <= prod;
	end

endmodule

FILE: rtl/imuca_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC vectoring unit: atan2(num, den) in Q16.16 degrees, one step per cycle.
module imuca_cordic #(
	parameter int STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [15:0]                num,
	input  logic signed [15:0]                den,
	output imuca_pkg::cordic_stat_t           stat,
	output logic signed [imuca_pkg::ZW-1:0]   angle
);

	localparam int IW = $clog2(STEPS);

	logic signed [imuca_pkg::XW-1:0] x_q, y_q, x_in, y_in, x0, y0, xs, ys;
	logic signed [imuca_pkg::ZW-1:0] z_q, z0, tab;
	logic [IW-1:0] i_q;
	logic          busy_q, done_q, zero_q, last;

	// operands scaled by 2^14
	assign x_in = $signed({{(imuca_pkg::XW-30){den[15]}}, den, 14'b0});
	assign y_in = $signed({{(imuca_pkg::XW-30){num[15]}}, num, 14'b0});

	// fold the left half-plane by a quarter turn
	always_comb begin
		x0 = x_in;
		y0 = y_in;
		z0 = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x0 = y_in;
				y0 = -x_in;
				z0 = imuca_pkg::Z_QUARTER;
			end else begin
				x0 = -y_in;
				y0 = x_in;
				z0 = -imuca_pkg::Z_QUARTER;
			end
		end
	end

	assign xs   = x_q >>> i_q;
	assign ys   = y_q >>> i_q;
	assign tab  = $signed(imuca_pkg::ZW'(imuca_pkg::atan_entry(5'(i_q))));
	assign last = (i_q == IW'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			zero_q <= 1'b0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				zero_q <= (num == 16'sd0) && (den == 16'sd0);
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (!y_q[imuca_pkg::XW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign angle     = zero_q ? '0 : z_q;

endmodule

FILE: rtl/imu_complementary_attitude_top.sv
`timescale 1ns / 1ps
// Top level of the complementary-filter IMU attitude estimator.
//
// Takes one raw IMU sample per transaction (three accelerometer axes, three gyro
// rates, raw temperature) and returns one transaction with blended pitch and roll,
// integrated yaw (all Q16.16 degrees, saturated to 32 bits) and temperature in
// 1/256 degC. Accelerometer pitch = -atan2(ax, az), roll = atan2(ay, az), found by
// an iterative CORDIC; gyro rates times gyro_step_gain step the kept angles, and
// pitch/roll are then blended with the accelerometer angles by blend_weight
// (values above 1.0 act as 1.0). The single CORDIC shift-add stage runs
// CORDIC_STEPS times per atan2 and twice per sample, and a six-step prologue
// plus a five-step blend run on one shared 33x18 multiplier.
// s_tready is high only between samples; a finished result sits in
// the output register, so a new sample is taken while it waits, and the block
// only stalls at the end of the next sample if that result is still not taken.
// Configuration writes (cfg_ready is always high) belong between samples;
// unknown indexes are ignored.
module imu_complementary_attitude_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// sample in
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temp_raw (16 bit each)
	input  logic [imuca_pkg::S_DATA_W-1:0]        s_tdata,
	// attitude out
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// pitch_deg[31:0], roll_deg[63:32], yaw_deg[95:64], temp_c[112:96], zero pad
	output logic [imuca_pkg::M_DATA_W-1:0]        m_tdata,
	// configuration write
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [imuca_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imuca_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// prologue steps on the shared multiplier
	localparam logic [2:0] PRE_GY   = 3'd0;  // gyro_y * gain
	localparam logic [2:0] PRE_GX   = 3'd1;  // gyro_x * gain, pitch gyro path out
	localparam logic [2:0] PRE_GZ   = 3'd2;  // gyro_z * gain, roll gyro path out
	localparam logic [2:0] PRE_TDIV = 3'd3;  // M * reciprocal, yaw out
	localparam logic [2:0] PRE_TMUL = 3'd4;  // quotient estimate * 34000
	localparam logic [2:0] PRE_TFIX = 3'd5;  // remainder correction
	// blend steps
	localparam logic [2:0] POST_PW   = 3'd0;
	localparam logic [2:0] POST_PA   = 3'd1;
	localparam logic [2:0] POST_RW   = 3'd2;
	localparam logic [2:0] POST_RA   = 3'd3;
	localparam logic [2:0] POST_RFIX = 3'd4;

	imuca_pkg::imuca_state_t state_q, state_d;
	logic [2:0] step_q, step_d;

	// configuration
	logic [15:0] gain_q;
	logic [16:0] weight_q, w_c, w_n;

	// captured sample
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [30:0]        m_q;
	logic signed [31:0] m_next;

	// kept state and intermediates
	logic signed [31:0] pitch_acc_q, roll_acc_q, yaw_acc_q;
	logic signed [31:0] pitch_g_q, roll_g_q;
	logic signed [imuca_pkg::ZW-1:0] pitch_a_q, roll_a_q;
	logic signed [imuca_pkg::MP_W-1:0] bacc_q;
	logic [15:0] q_est_q;
	logic [16:0] temp_q;

	// output register
	logic        m_tvalid_q;
	logic [imuca_pkg::M_DATA_W-1:0] m_tdata_q;
	logic        out_free;

	// shared units
	logic signed [imuca_pkg::MA_W-1:0] mul_a;
	logic signed [imuca_pkg::MB_W-1:0] mul_b;
	logic signed [imuca_pkg::MP_W-1:0] mul_p;
	logic                              cd_start;
	logic signed [15:0]                cd_num;
	imuca_pkg::cordic_stat_t           cd_stat;
	logic signed [imuca_pkg::ZW-1:0]   cd_angle;

	// datapath helpers
	logic signed [25:0] g_inc;
	logic signed [imuca_pkg::MP_W-1:0] g_inc_x;
	logic signed [imuca_pkg::MP_W-1:0] bsum;
	logic signed [31:0] blend_out;
	logic [31:0] t_rem;
	logic [17:0] t_sum;

	// gyro increment: floor((rate * gain + 128) / 256)
	function automatic logic signed [25:0] gyro_inc(input logic signed [imuca_pkg::MP_W-1:0] p);
		logic signed [33:0] s;
		s = $signed(p[33:0]) + 34'sd128;
		return s[33:8];
	endfunction

	assign s_tready  = (state_q == imuca_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign w_c = (weight_q > imuca_pkg::WEIGHT_ONE) ? imuca_pkg::WEIGHT_ONE : weight_q;
	assign w_n = imuca_pkg::WEIGHT_ONE - w_c;

	assign m_next = 32'($signed(s_tdata[111:96]) * imuca_pkg::TEMP_GAIN) + imuca_pkg::TEMP_OFS;

	assign g_inc   = gyro_inc(mul_p);
	assign g_inc_x = imuca_pkg::MP_W'(g_inc);
	assign bsum    = (bacc_q + mul_p + 51'sd32768) >>> 16;
	assign blend_out = imuca_pkg::sat32(bsum);
	assign t_rem   = {1'b0, m_q} - mul_p[31:0];
	assign t_sum   = {2'b00, q_est_q} + {17'b0, (t_rem >= 32'd34000)} - imuca_pkg::TEMP_BIAS_Q;

	imuca_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	assign cd_num = (state_q == imuca_pkg::ST_ROLL_GO) ? ay_q : ax_q;

	imuca_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start),
		.num    (cd_num),
		.den    (az_q),
		.stat   (cd_stat),
		.angle  (cd_angle)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imuca_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// next state, multiplier operand select, CORDIC launch
	always_comb begin
		state_d  = state_q;
		step_d   = '0;
		mul_a    = '0;
		mul_b    = '0;
		cd_start = 1'b0;
		case (state_q)
			imuca_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = imuca_pkg::ST_PRE;
				end
			end
			imuca_pkg::ST_PRE: begin
				step_d = step_q + 3'd1;
				case (step_q)
					PRE_GY: begin
						mul_a = imuca_pkg::MA_W'(gy_q);
						mul_b = $signed({2'b00, gain_q});
					end
					PRE_GX: begin
						mul_a = imuca_pkg::MA_W'(gx_q);
						mul_b = $signed({2'b00, gain_q});
					end
					PRE_GZ: begin
						mul_a = imuca_pkg::MA_W'(gz_q);
						mul_b = $signed({2'b00, gain_q});
					end
					PRE_TDIV: begin
						mul_a = $signed({2'b00, m_q});
						mul_b = $signed(imuca_pkg::TEMP_RECIP);
					end
					PRE_TMUL: begin
						mul_a = $signed({17'b0, mul_p[47:32]});
						mul_b = $signed(imuca_pkg::TEMP_DIV);
					end
					PRE_TFIX: begin
						step_d  = '0;
						state_d = imuca_pkg::ST_PITCH_GO;
					end
					default: begin
						step_d  = '0;
						state_d = imuca_pkg::ST_PITCH_GO;
					end
				endcase
			end
			imuca_pkg::ST_PITCH_GO: begin
				cd_start = 1'b1;
				state_d  = imuca_pkg::ST_PITCH_RUN;
			end
			imuca_pkg::ST_PITCH_RUN: begin
				if (cd_stat.done) begin
					state_d = imuca_pkg::ST_ROLL_GO;
				end
			end
			imuca_pkg::ST_ROLL_GO: begin
				cd_start = 1'b1;
				state_d  = imuca_pkg::ST_ROLL_RUN;
			end
			imuca_pkg::ST_ROLL_RUN: begin
				if (cd_stat.done) begin
					state_d = imuca_pkg::ST_POST;
				end
			end
			imuca_pkg::ST_POST: begin
				step_d = step_q + 3'd1;
				case (step_q)
					POST_PW: begin
						mul_a = imuca_pkg::MA_W'(pitch_g_q);
						mul_b = $signed({1'b0, w_c});
					end
					POST_PA: begin
						mul_a = imuca_pkg::MA_W'(pitch_a_q);
						mul_b = $signed({1'b0, w_n});
					end
					POST_RW: begin
						mul_a = imuca_pkg::MA_W'(roll_g_q);
						mul_b = $signed({1'b0, w_c});
					end
					POST_RA: begin
						mul_a = imuca_pkg::MA_W'(roll_a_q);
						mul_b = $signed({1'b0, w_n});
					end
					POST_RFIX: begin
						step_d  = '0;
						state_d = imuca_pkg::ST_DONE;
					end
					default: begin
						step_d  = '0;
						state_d = imuca_pkg::ST_DONE;
					end
				endcase
			end
			imuca_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = imuca_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = imuca_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= imuca_pkg::GAIN_RESET;
			weight_q <= imuca_pkg::WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				imuca_pkg::REG_GYRO_GAIN:    gain_q   <= cfg_data[15:0];
				imuca_pkg::REG_BLEND_WEIGHT: weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// kept angles and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_acc_q <= '0;
			roll_acc_q  <= '0;
			yaw_acc_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (state_q == imuca_pkg::ST_PRE && step_q == PRE_TDIV) begin
				yaw_acc_q <= imuca_pkg::sat32(imuca_pkg::MP_W'(yaw_acc_q) + g_inc_x);
			end
			if (state_q == imuca_pkg::ST_POST && step_q == POST_RW) begin
				pitch_acc_q <= blend_out;
			end
			if (state_q == imuca_pkg::ST_POST && step_q == POST_RFIX) begin
				roll_acc_q <= blend_out;
			end
			// a new result replaces one taken in the same cycle
			if (state_q == imuca_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ax_q <= s_tdata[15:0];
			ay_q <= s_tdata[31:16];
			az_q <= s_tdata[47:32];
			gx_q <= s_tdata[63:48];
			gy_q <= s_tdata[79:64];
			gz_q <= s_tdata[95:80];
			m_q  <= m_next[30:0];
		end
		if (state_q == imuca_pkg::ST_PRE) begin
			case (step_q)
				PRE_GX: pitch_g_q <= imuca_pkg::sat32(imuca_pkg::MP_W'(pitch_acc_q) + g_inc_x);
				PRE_GZ: roll_g_q  <= imuca_pkg::sat32(imuca_pkg::MP_W'(roll_acc_q) + g_inc_x);
				PRE_TMUL: q_est_q <= mul_p[47:32];
				PRE_TFIX: temp_q  <= t_sum[16:0];
				default: ;
			endcase
		end
		if (state_q == imuca_pkg::ST_PITCH_RUN && cd_stat.done) begin
			pitch_a_q <= -cd_angle;
		end
		if (state_q == imuca_pkg::ST_ROLL_RUN && cd_stat.done) begin
			roll_a_q <= cd_angle;
		end
		if (state_q == imuca_pkg::ST_POST && (step_q == POST_PA || step_q == POST_RA)) begin
			bacc_q <= mul_p;
		end
		if (state_q == imuca_pkg::ST_DONE && out_free) begin
			m_tdata_q <= {7'b0, temp_q, yaw_acc_q, roll_acc_q, pitch_acc_q};
		end
	end

`ifndef SYNTHESIS
	// CORDIC only finishes while the sequencer waits on it
	a_cordic_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cd_stat.done |-> (state_q == imuca_pkg::ST_PITCH_RUN || state_q == imuca_pkg::ST_ROLL_RUN))
		else $error("CORDIC done outside a wait state");

	// one sample at a time
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("sample accepted while busy");

	// temperature from the reciprocal divide stays in the sensor range
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[112:96]) >= -17'sd15321 &&
			$signed(m_tdata[112:96]) <= 17'sd34025))
		else $error("temperature out of range");
`endif

endmodule
